/* rtl/core/hvg_pkg.sv */
`timescale 1ns / 1ps
// hvg_pkg: shared types, codes and constants of the heightmap vertex generator
// no dependencies
package hvg_pkg;

   localparam int MAX_SIDE   = 256;
   localparam int SIDE_W     = 9;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_NUM_W  = 46;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_CNT_W  = 6;
   localparam int SQRT_W     = 62;
   localparam int ROOT_W     = 31;
   localparam int SQRT_CNT_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_SCALE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_SIZE   = 8'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // slots of the five samples around a query point
   localparam logic [2:0] RD_CENTER = 3'd0;
   localparam logic [2:0] RD_LEFT   = 3'd1;
   localparam logic [2:0] RD_RIGHT  = 3'd2;
   localparam logic [2:0] RD_DOWN   = 3'd3;
   localparam logic [2:0] RD_UP     = 3'd4;

   localparam logic [31:0]          NORM_B_MAG = 32'd130560;
   localparam logic [14:0]          NORM_ONE   = 15'd16384;
   localparam logic [21:0]          TEX_MAX    = 22'h3FFFFF;

   typedef struct packed {
      logic       req_type;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] sample;
   } hvg_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [21:0]        tex_u;
      logic [21:0]        tex_v;
   } hvg_rsp_type;

   typedef enum logic [2:0] {
      OP_POS_X, OP_POS_Z, OP_TEX_U, OP_TEX_V, OP_NORM_X, OP_NORM_Y, OP_NORM_Z
   } hvg_div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRITE, ST_CLAMP, ST_READ, ST_READ_WAIT, ST_MUL, ST_SHIFT, ST_SQUARE,
      ST_SUM, ST_SQRT_GO, ST_SQRT, ST_DIV_GO, ST_DIV_WAIT, ST_RESULT
   } hvg_state_type;

   typedef struct packed {
      logic           capture;
      logic           mem_write;
      logic           clamp;
      logic           rd_en;
      logic [2:0]     rd_idx;
      logic           mul;
      logic           shift;
      logic           square;
      logic           sum;
      logic           sqrt_start;
      logic           div_start;
      logic           div_store;
      hvg_div_op_type div_op;
      logic           out_load;
   } hvg_cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
   } hvg_status_type;

endpackage

/* rtl/core/hvg_div.sv */
`timescale 1ns / 1ps
// hvg_div: restoring divider, one quotient bit per cycle, rounds half up
// depends on hvg_pkg
module hvg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hvg_pkg::DIV_NUM_W-1:0]  num,
   input  logic [hvg_pkg::DIV_DEN_W-1:0]  den,
   output logic [hvg_pkg::DIV_NUM_W-1:0]  quot,
   output logic                           done
);
   import hvg_pkg::*;

   logic [DIV_NUM_W-1:0] n_ff;
   logic [DIV_DEN_W:0]   rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff[DIV_DEN_W-1:0], n_ff[DIV_NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // adding half the divisor gives round to nearest
         n_ff   <= num + DIV_NUM_W'(den >> 1);
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         n_ff   <= {n_ff[DIV_NUM_W-2:0], ge};
      end
   end

   assign quot = n_ff;
   assign done = done_ff;

endmodule

/* rtl/core/hvg_sqrt.sv */
`timescale 1ns / 1ps
// hvg_sqrt: bit-pair integer square root, one result bit per cycle
// depends on hvg_pkg
module hvg_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hvg_pkg::SQRT_W-1:0]  radicand,
   output logic [hvg_pkg::ROOT_W-1:0]  root,
   output logic                        done
);
   import hvg_pkg::*;

   logic [SQRT_W-1:0]     v_ff;
   logic [SQRT_W-1:0]     res_ff;
   logic [SQRT_W-1:0]     bit_ff;
   logic [SQRT_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [SQRT_W:0]       trial;
   logic                  ge;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign ge    = {1'b0, v_ff} >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == SQRT_CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= SQRT_W'(1) << (SQRT_W - 2);
      end else if (busy_ff) begin
         if (ge) begin
            v_ff   <= v_ff - trial[SQRT_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign root = res_ff[ROOT_W-1:0];
   assign done = done_ff;

endmodule

/* rtl/core/hvg_datapath.sv */
`timescale 1ns / 1ps
// hvg_datapath: config registers, height memory, vertex arithmetic, result register
// depends on hvg_pkg, hvg_div, hvg_sqrt
module hvg_datapath #(
   parameter int TEX_REPEAT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hvg_pkg::hvg_cmd_type                cmd,
   output hvg_pkg::hvg_status_type             status,
   input  hvg_pkg::hvg_req_type                req_data,
   input  logic                                csr_write,
   input  logic [hvg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hvg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output hvg_pkg::hvg_rsp_type                rsp_data
);
   import hvg_pkg::*;

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [SIDE_W-1:0]     map_width_ff, map_height_ff;
   logic [23:0]           height_scale_ff, world_size_ff;
   hvg_req_type           req_ff;
   logic [7:0]            mem [DEPTH];
   logic [7:0]            mem_q_ff;
   logic                  rd_valid_ff;
   logic [2:0]            rd_idx_ff;
   logic [7:0]            samp_ff [5];
   logic [SIDE_W-1:0]     c_ff, r_ff, wm1_ff, hm1_ff;
   logic [SIDE_W-1:0]     w_eff, h_eff, wm1, hm1;
   logic [SIDE_W-1:0]     cl, cr, rdn, rup, rd_c, rd_r;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic                  wr_in_range;
   // products of the multiply step
   logic [31:0]           amag_ff, dmag_ff, ymag_ff;
   logic [33:0]           pxmag_ff, pzmag_ff;
   logic                  a_neg_ff, d_neg_ff, y_neg_ff, px_neg_ff, pz_neg_ff;
   logic [29:0]           nmag_ff [3];
   logic [59:0]           sq_ff [3];
   logic [SQRT_W-1:0]     sum_ff;
   logic [ROOT_W-1:0]     root;
   logic                  sqrt_done;
   logic [DIV_NUM_W-1:0]  div_num, quot;
   logic [DIV_DEN_W-1:0]  div_den;
   logic                  div_done;
   hvg_rsp_type           res_ff, rsp_ff;
   // height divide by 255
   logic [39:0]           y_x_ff, y_q_ff, y_quot;
   logic [2:0]            y_cnt_ff;
   logic [31:0]           y_q32;
   // multiply step inputs
   logic [7:0]            ymag8, amag8, dmag8;
   logic [SIDE_W:0]       two_c, two_r, pxmag10, pzmag10;
   logic [31:0]           mmax;
   logic [1:0]            k;
   logic [14:0]           capq;
   logic [31:0]           q32;
   logic                  div_neg;

   always_comb begin
      if (map_width_ff < SIDE_W'(2)) w_eff = SIDE_W'(2);
      else if (32'(map_width_ff) > MAX_SIDE) w_eff = SIDE_W'(MAX_SIDE);
      else w_eff = map_width_ff;
      if (map_height_ff < SIDE_W'(2)) h_eff = SIDE_W'(2);
      else if (32'(map_height_ff) > MAX_SIDE) h_eff = SIDE_W'(MAX_SIDE);
      else h_eff = map_height_ff;
   end
   assign wm1 = w_eff - 1'b1;
   assign hm1 = h_eff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= SIDE_W'(256);
         map_height_ff   <= SIDE_W'(256);
         height_scale_ff <= 24'd256;
         world_size_ff   <= 24'd65536;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAP_WIDTH:    map_width_ff    <= csr_wdata[SIDE_W-1:0];
            CSR_MAP_HEIGHT:   map_height_ff   <= csr_wdata[SIDE_W-1:0];
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            CSR_WORLD_SIZE:   world_size_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // neighbors clamped to the map edge
   assign cl  = (c_ff == '0) ? '0 : c_ff - 1'b1;
   assign cr  = ((c_ff + 1'b1) < wm1_ff + 1'b1) ? c_ff + 1'b1 : wm1_ff;
   assign rdn = (r_ff == '0) ? '0 : r_ff - 1'b1;
   assign rup = ((r_ff + 1'b1) < hm1_ff + 1'b1) ? r_ff + 1'b1 : hm1_ff;

   always_comb begin
      rd_c = c_ff;
      rd_r = r_ff;
      case (cmd.rd_idx)
         RD_LEFT:  rd_c = cl;
         RD_RIGHT: rd_c = cr;
         RD_DOWN:  rd_r = rdn;
         RD_UP:    rd_r = rup;
         default: ;
      endcase
   end

   assign rd_addr     = ADDR_W'(32'(rd_r) * MAX_SIDE + 32'(rd_c));
   assign wr_addr     = ADDR_W'(32'(req_ff.row) * MAX_SIDE + 32'(req_ff.col));
   assign wr_in_range = (32'(req_ff.col) < MAX_SIDE) && (32'(req_ff.row) < MAX_SIDE);

   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_in_range) mem[wr_addr] <= req_ff.sample;
      if (cmd.rd_en) mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= cmd.rd_en;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      rd_idx_ff <= cmd.rd_idx;
      if (rd_valid_ff) samp_ff[rd_idx_ff] <= mem_q_ff;
      if (cmd.clamp) begin
         c_ff   <= ({1'b0, req_ff.col} < wm1) ? {1'b0, req_ff.col} : wm1;
         r_ff   <= ({1'b0, req_ff.row} < hm1) ? {1'b0, req_ff.row} : hm1;
         wm1_ff <= wm1;
         hm1_ff <= hm1;
      end
   end

   // magnitudes of 2s-255, hL-hR, hD-hU, 2c-(W-1) and 2r-(H-1)
   assign ymag8   = samp_ff[RD_CENTER][7] ? 8'({samp_ff[RD_CENTER], 1'b0} - 9'd255)
                                          : 8'(9'd255 - {samp_ff[RD_CENTER], 1'b0});
   assign amag8   = (samp_ff[RD_LEFT] < samp_ff[RD_RIGHT])
                    ? samp_ff[RD_RIGHT] - samp_ff[RD_LEFT] : samp_ff[RD_LEFT] - samp_ff[RD_RIGHT];
   assign dmag8   = (samp_ff[RD_DOWN] < samp_ff[RD_UP])
                    ? samp_ff[RD_UP] - samp_ff[RD_DOWN] : samp_ff[RD_DOWN] - samp_ff[RD_UP];
   assign two_c   = {c_ff, 1'b0};
   assign two_r   = {r_ff, 1'b0};
   assign pxmag10 = (two_c < {1'b0, wm1_ff}) ? {1'b0, wm1_ff} - two_c : two_c - {1'b0, wm1_ff};
   assign pzmag10 = (two_r < {1'b0, hm1_ff}) ? {1'b0, hm1_ff} - two_r : two_r - {1'b0, hm1_ff};

   always_comb begin
      mmax = (amag_ff > NORM_B_MAG) ? amag_ff : NORM_B_MAG;
      if (dmag_ff > mmax) mmax = dmag_ff;
      if (mmax[31]) k = 2'd2;
      else if (mmax[30]) k = 2'd1;
      else k = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         ymag_ff   <= 32'(ymag8) * 32'(height_scale_ff);
         y_neg_ff  <= ~samp_ff[RD_CENTER][7];
         amag_ff   <= 32'(amag8) * 32'(height_scale_ff);
         a_neg_ff  <= samp_ff[RD_LEFT] < samp_ff[RD_RIGHT];
         dmag_ff   <= 32'(dmag8) * 32'(height_scale_ff);
         d_neg_ff  <= samp_ff[RD_DOWN] < samp_ff[RD_UP];
         pxmag_ff  <= 34'(pxmag10) * 34'(world_size_ff);
         px_neg_ff <= two_c < {1'b0, wm1_ff};
         pzmag_ff  <= 34'(pzmag10) * 34'(world_size_ff);
         pz_neg_ff <= two_r < {1'b0, hm1_ff};
      end
      if (cmd.shift) begin
         nmag_ff[0] <= 30'(amag_ff >> k);
         nmag_ff[1] <= 30'(NORM_B_MAG >> k);
         nmag_ff[2] <= 30'(dmag_ff >> k);
      end
      if (cmd.square) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= 60'(nmag_ff[i]) * 60'(nmag_ff[i]);
      end
      if (cmd.sum) sum_ff <= SQRT_W'(sq_ff[0]) + SQRT_W'(sq_ff[1]) + SQRT_W'(sq_ff[2]);
   end

   // height over 255: 256a+b is 255a+(a+b), five folds then one compare,
   // done long before the first division finishes
   always_ff @(posedge clock) begin
      if (reset) y_cnt_ff <= '0;
      else if (cmd.shift) y_cnt_ff <= 3'd6;
      else if (y_cnt_ff != '0) y_cnt_ff <= y_cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         y_x_ff <= 40'({ymag_ff, 7'd0}) + 40'd127;
         y_q_ff <= '0;
      end else if (y_cnt_ff > 3'd1) begin
         y_x_ff <= 40'(y_x_ff[39:8]) + 40'(y_x_ff[7:0]);
         y_q_ff <= y_q_ff + 40'(y_x_ff[39:8]);
      end
   end

   assign y_quot = y_q_ff + ((y_x_ff >= 40'd255) ? 40'd1 : 40'd0);
   assign y_q32  = y_quot[31:0];

   hvg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sum_ff),
      .root     (root),
      .done     (sqrt_done)
   );

   always_comb begin
      div_num = '0;
      div_den = DIV_DEN_W'(root);
      div_neg = 1'b0;
      case (cmd.div_op)
         OP_POS_X: begin
            div_num = DIV_NUM_W'({pxmag_ff, 7'd0});
            div_den = DIV_DEN_W'(wm1_ff);
            div_neg = px_neg_ff;
         end
         OP_POS_Z: begin
            div_num = DIV_NUM_W'({pzmag_ff, 7'd0});
            div_den = DIV_DEN_W'(hm1_ff);
            div_neg = pz_neg_ff;
         end
         OP_TEX_U: begin
            div_num = (DIV_NUM_W'(c_ff) * DIV_NUM_W'(TEX_REPEAT)) << 16;
            div_den = DIV_DEN_W'(wm1_ff);
         end
         OP_TEX_V: begin
            div_num = (DIV_NUM_W'(r_ff) * DIV_NUM_W'(TEX_REPEAT)) << 16;
            div_den = DIV_DEN_W'(hm1_ff);
         end
         OP_NORM_X: begin
            div_num = DIV_NUM_W'({nmag_ff[0], 14'd0});
            div_neg = a_neg_ff;
         end
         OP_NORM_Y: div_num = DIV_NUM_W'({nmag_ff[1], 14'd0});
         OP_NORM_Z: begin
            div_num = DIV_NUM_W'({nmag_ff[2], 14'd0});
            div_neg = d_neg_ff;
         end
         default: ;
      endcase
   end

   hvg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .done  (div_done)
   );

   assign q32  = quot[31:0];
   assign capq = (quot > DIV_NUM_W'(NORM_ONE)) ? NORM_ONE : quot[14:0];

   always_ff @(posedge clock) begin
      if (y_cnt_ff == 3'd1) begin
         // saturate to the signed 32-bit range
         if (!y_neg_ff && y_quot > 40'h7FFF_FFFF) res_ff.pos_y <= 32'h7FFF_FFFF;
         else if (y_neg_ff && y_quot > 40'h8000_0000) res_ff.pos_y <= 32'h8000_0000;
         else res_ff.pos_y <= y_neg_ff ? -y_q32 : y_q32;
      end
      if (cmd.div_store) begin
         case (cmd.div_op)
            OP_POS_X: res_ff.pos_x <= div_neg ? -q32 : q32;
            OP_POS_Z: res_ff.pos_z <= div_neg ? -q32 : q32;
            OP_TEX_U: res_ff.tex_u <= (quot > DIV_NUM_W'(TEX_MAX)) ? TEX_MAX : quot[21:0];
            OP_TEX_V: res_ff.tex_v <= (quot > DIV_NUM_W'(TEX_MAX)) ? TEX_MAX : quot[21:0];
            OP_NORM_X: res_ff.norm_x <= div_neg ? -{1'b0, capq} : {1'b0, capq};
            OP_NORM_Y: res_ff.norm_y <= {1'b0, capq};
            OP_NORM_Z: res_ff.norm_z <= div_neg ? -{1'b0, capq} : {1'b0, capq};
            default: ;
         endcase
      end
      if (cmd.out_load) rsp_ff <= res_ff;
   end

   assign rsp_data         = rsp_ff;
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;

endmodule

/* rtl/core/hvg_ctrl.sv */
`timescale 1ns / 1ps
// hvg_ctrl: sequencer for writes and vertex queries, owns the req and rsp handshakes
// depends on hvg_pkg
module hvg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_is_query,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hvg_pkg::hvg_cmd_type     cmd,
   input  hvg_pkg::hvg_status_type  status
);
   import hvg_pkg::*;

   hvg_state_type  state_ff, state_in;
   logic [2:0]     rd_cnt_ff, rd_cnt_in;
   hvg_div_op_type op_ff, op_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         op_ff        <= OP_POS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rd_idx   = rd_cnt_ff;
      cmd.div_op   = op_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_is_query == REQ_QUERY) ? ST_CLAMP : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            rd_cnt_in = RD_CENTER;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == RD_UP) state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               op_in    = OP_POS_X;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (op_ff == OP_NORM_Z) begin
                  state_in = ST_RESULT;
               end else begin
                  op_in    = hvg_div_op_type'(3'(op_ff + 3'd1));
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_RESULT: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/heightmap_vertex_generator_core.sv */
`timescale 1ns / 1ps
// heightmap_vertex_generator_core: top level, joins sequencer and datapath
// depends on hvg_pkg, hvg_ctrl, hvg_datapath
//
//   channel  handshake               payload
//   req      req_valid / req_ready   req_data   (hvg_req_type)
//   rsp      rsp_valid / rsp_ready   rsp_data   (hvg_rsp_type)
//   csr      csr_valid / csr_ready   csr_index, csr_wdata
//
// a query runs the 31-step square root and then seven 46-step serial divisions
// in sequence; the height divide by 255 starts at the shift step and runs beside
// the square, the sum and the square root
// one transaction is in work at a time; the finished vertex waits in an output
// register, and a new transaction is taken while it waits
// reset clears control and config registers; the height memory is not cleared
// csr_ready is always high
module heightmap_vertex_generator_core #(
   parameter int TEX_REPEAT = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hvg_pkg::hvg_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hvg_pkg::hvg_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hvg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hvg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hvg_pkg::*;

   hvg_cmd_type    cmd;
   hvg_status_type status;

   assign csr_ready = 1'b1;

   hvg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_is_query (req_data.req_type),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status)
   );

   hvg_datapath #(
      .TEX_REPEAT (TEX_REPEAT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
